[design/tac_pkg.sv]
// shared types and constants for the temperature alarm controller
// no dependencies; imported by tac_step and temperature_alarm_controller
package tac_pkg;

	// mode codes
	localparam logic [1:0] MODE_MAIN   = 2'd0;
	localparam logic [1:0] MODE_CONFIG = 2'd1;
	localparam logic [1:0] MODE_ALARM  = 2'd2;

	// item kinds
	localparam logic FUNC_CHAR   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// command characters
	localparam logic [7:0] CHAR_NONE   = 8'h00;
	localparam logic [7:0] CHAR_CONFIG = 8'h43; // 'C'
	localparam logic [7:0] CHAR_TOGGLE = 8'h54; // 'T'
	localparam logic [7:0] CHAR_OK     = 8'h4F; // 'O'
	localparam logic [7:0] CHAR_SILENT = 8'h53; // 'S'
	localparam logic [7:0] CHAR_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CHAR_NINE   = 8'h39; // '9'

	// display update flags
	localparam logic [6:0] FLAG_MAIN   = 7'h01;
	localparam logic [6:0] FLAG_ALARM  = 7'h02;
	localparam logic [6:0] FLAG_CONFIG = 7'h04;
	localparam logic [6:0] FLAG_TEMP   = 7'h08;
	localparam logic [6:0] FLAG_LIMIT  = 7'h10;
	localparam logic [6:0] FLAG_DIGIT  = 7'h20;
	localparam logic [6:0] FLAG_STATUS = 7'h40;

	localparam logic [6:0] FLAGS_BACK_TO_MAIN = FLAG_MAIN | FLAG_TEMP | FLAG_LIMIT | FLAG_STATUS;

	localparam logic [1:0] MAX_DIGITS = 2'd3;
	localparam logic [7:0] DEG_MAX    = 8'd255;
	// raw*5000/1024/10 reduces to raw*125/256
	localparam logic [16:0] DEG_SCALE = 17'd125;

	typedef struct packed {
		logic       func;
		logic [7:0] char_code;
		logic [9:0] adc_sample;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       alarm_enabled;
		logic       alarm_active;
		logic [7:0] current_temp;
		logic [7:0] threshold_temp;
		logic [9:0] entry_value;
		logic [1:0] digits_entered;
		logic [7:0] echo_digit;
		logic [6:0] display_flags;
	} res_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       enable;
		logic       alarm;
		logic [7:0] temp;
		logic [7:0] limit;
		logic [9:0] entry;
		logic [1:0] digit_count;
		logic [7:0] last_digit;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode:        MODE_MAIN,
		enable:      1'b1,
		alarm:       1'b0,
		temp:        8'd0,
		limit:       8'd100,
		entry:       10'd0,
		digit_count: 2'd0,
		last_digit:  8'd0
	};

endpackage

[design/temperature_alarm_controller.sv]
// top level of the over-temperature alarm controller: input register, state and result register
// depends on tac_pkg and tac_step
//
// Takes one item per clock cycle unless stalled, either a command character or a raw ten-bit
// temperature reading, and returns exactly one result item for each: the controller state
// after the item (mode, alarm enable and drive, temperature and threshold in degrees,
// threshold digits being entered, last echoed digit) plus the display update flags raised
// by that item. An item passes through an input register and a result register: its result
// is registered when it leaves the input register, which a result stall can delay. The state
// update for an item lands in the same cycle as its result is registered, which lets the next
// item follow in the very next cycle. Result stall holds the result register and, once the
// input register is also full, raises cmd_stall.
module temperature_alarm_controller import tac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	state_t     state_q;
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       res_valid_q;
	res_t       res_q;
	state_t     nxt;
	logic [6:0] flags;
	logic       advance;

	tac_step u_step (
		.cmd   (cmd_s1),
		.cur   (state_q),
		.nxt   (nxt),
		.flags (flags)
	);

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else begin
			if (!cmd_stall)
				valid_s1 <= cmd_valid;
			if (advance)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (advance)
				state_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
		if (advance) begin
			res_q.mode           <= nxt.mode;
			res_q.alarm_enabled  <= nxt.enable;
			res_q.alarm_active   <= nxt.alarm;
			res_q.current_temp   <= nxt.temp;
			res_q.threshold_temp <= nxt.limit;
			res_q.entry_value    <= nxt.entry;
			res_q.digits_entered <= nxt.digit_count;
			res_q.echo_digit     <= nxt.last_digit;
			res_q.display_flags  <= flags;
		end
	end

`ifndef SYNTHESIS
	// alarm drive is on exactly while in alarm mode
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.alarm == (state_q.mode == MODE_ALARM))
		else $error("alarm drive out of step with mode");

	// an item held in the input register is never dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("stalled item lost from input register");

	// state only moves when an item is handed to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an item");
`endif

endmodule

[design/tac_step.sv]
// next-state and display flag logic for one item of the alarm controller
// depends on tac_pkg
module tac_step import tac_pkg::*; (
	input  cmd_t       cmd,
	input  state_t     cur,
	output state_t     nxt,
	output logic [6:0] flags
);

	always_comb begin
		logic        trig;
		logic [16:0] prod;
		logic [8:0]  deg_full;
		logic [7:0]  deg;
		logic [3:0]  digit;
		logic [13:0] entry_ext;

		nxt   = cur;
		flags = '0;
		trig  = 1'b0;

		prod     = 17'(cmd.adc_sample) * DEG_SCALE;
		deg_full = prod[16:8];
		deg      = (deg_full > 9'(DEG_MAX)) ? DEG_MAX : deg_full[7:0];

		// low nibble of an ascii digit is its value
		digit     = cmd.char_code[3:0];
		entry_ext = 14'({cur.entry, 3'b000}) + 14'({cur.entry, 1'b0}) + 14'(digit);

		if (cmd.func == FUNC_CHAR) begin
			if (cmd.char_code != CHAR_NONE) begin
				case (cur.mode)
					MODE_MAIN: begin
						if (cmd.char_code == CHAR_CONFIG) begin
							nxt.mode        = MODE_CONFIG;
							nxt.digit_count = 2'd0;
							nxt.entry       = 10'd0;
							flags           = flags | FLAG_CONFIG;
						end else if (cmd.char_code == CHAR_TOGGLE) begin
							nxt.enable = ~cur.enable;
							flags      = flags | FLAG_STATUS;
							trig       = 1'b1;
						end
					end
					MODE_CONFIG: begin
						if (cmd.char_code == CHAR_OK) begin
							nxt.limit = (cur.entry > 10'(DEG_MAX)) ? DEG_MAX : cur.entry[7:0];
							nxt.mode  = MODE_MAIN;
							flags     = flags | FLAGS_BACK_TO_MAIN;
							trig      = 1'b1;
						end else if (cmd.char_code == CHAR_CONFIG) begin
							nxt.mode = MODE_MAIN;
							flags    = flags | FLAGS_BACK_TO_MAIN;
						end else if (cmd.char_code inside {[CHAR_ZERO:CHAR_NINE]} &&
							cur.digit_count < MAX_DIGITS) begin
							nxt.digit_count = cur.digit_count + 2'd1;
							nxt.entry       = entry_ext[9:0];
							nxt.last_digit  = cmd.char_code;
							flags           = flags | FLAG_DIGIT;
						end
					end
					MODE_ALARM: begin
						if (cmd.char_code == CHAR_SILENT) begin
							nxt.enable = 1'b0;
							trig       = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			// samples are ignored while a threshold is being typed in
			if (deg != cur.temp && cur.mode != MODE_CONFIG) begin
				nxt.temp = deg;
				if (cur.mode == MODE_MAIN)
					flags = flags | FLAG_TEMP;
				trig = 1'b1;
			end
		end

		// alarm re-check on the updated state
		if (trig) begin
			if (nxt.mode == MODE_MAIN && nxt.enable && nxt.temp > nxt.limit) begin
				nxt.mode  = MODE_ALARM;
				nxt.alarm = 1'b1;
				flags     = flags | FLAG_ALARM;
			end else if (nxt.mode == MODE_ALARM && (!nxt.enable || nxt.temp < nxt.limit)) begin
				nxt.alarm = 1'b0;
				nxt.mode  = MODE_MAIN;
				flags     = flags | FLAGS_BACK_TO_MAIN;
			end
		end
	end

endmodule
